// ===== src/tps_pkg.sv =====
// Shared types and constants for the tour path stack.
`default_nettype none
package tps_pkg;

   localparam int NODE_W = 5;
   localparam int DIST_W = 16;
   localparam int CNT_W  = 6;
   localparam int LEN_W  = 21;
   localparam int MASK_W = 32;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH         = 2'd0,
      OP_PUSH_CHECKED = 2'd1,
      OP_POP          = 2'd2,
      OP_CLEAR        = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE     = 2'd0,
      ST_REFUSED  = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   // One stack entry: the node and the distance of the edge that reached it.
   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [DIST_W-1:0] distance;
   } entry_type;

endpackage
`default_nettype wire

// ===== src/tour_path_stack.sv =====
// Top level of the tour path stack: stack memory, visited bitmap and tour length.
`default_nettype none
// Usage
// A command word (req_operation, req_node, req_edge_distance) is taken at a rising
// clock edge where start is high and busy is low. Operations are push, checked push,
// pop of the tail and clear. Each command yields exactly one result word on the rsp_
// ports, shown for one cycle with rsp_strobe high; the receiver cannot stall it, so
// results must be taken as they come.
// Timing: push, checked push and clear put their result out in the cycle after
// acceptance; busy stays low, so one such command can be taken every cycle. A pop
// must first read the tail entry back from the stack memory, whose read data are
// registered; busy is high while that read completes and the result follows it.
// The path capacity register is written through the csr_ channel (valid/ready) while
// the block is idle. Reset empties the path, clears the bitmap and the length, and
// sets the capacity to 32. The stack memory itself is not cleared: only entries below
// the current node count are ever read back, and each of those was written by a push.
module tour_path_stack #(
   parameter int MAX_NODES = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [tps_pkg::OP_W-1:0]        req_operation,
   input  wire logic [tps_pkg::NODE_W-1:0]      req_node,
   input  wire logic [tps_pkg::DIST_W-1:0]      req_edge_distance,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tps_pkg::CNT_W-1:0]       csr_data,
   output logic                                 rsp_strobe,
   output logic [tps_pkg::STAT_W-1:0]           rsp_status,
   output logic [tps_pkg::CNT_W-1:0]            rsp_node_count,
   output logic [tps_pkg::LEN_W-1:0]            rsp_tour_length,
   output logic [tps_pkg::MASK_W-1:0]           rsp_visited_set
);
   import tps_pkg::*;

   localparam int AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CAP_W = CNT_W + 1;

   // Architectural state.
   logic [CNT_W-1:0]  size_ff, size_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]  cap_ff;
   logic              pop_pend_ff, pop_pend_in;

   // Result register.
   logic              strobe_ff, strobe_in;
   status_type        stat_ff, stat_in;

   // Stack memory, one entry per path position.
   entry_type         mem [MAX_NODES];
   entry_type         rd_data_ff;
   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   entry_type         wr_data;

   logic              accept;
   op_type            op;
   logic [CAP_W-1:0]  eff_cap;
   logic              full;
   logic              seen;
   logic [CNT_W-1:0]  size_m1;
   logic [DIST_W-1:0] dist_eff;

   assign accept    = start && !busy;
   assign op        = op_type'(req_operation);
   assign busy      = pop_pend_ff;
   assign csr_ready = !pop_pend_ff;

   // The capacity saturates at the memory depth; zero makes every push overflow.
   assign eff_cap = ({1'b0, cap_ff} > CAP_W'(MAX_NODES)) ? CAP_W'(MAX_NODES)
                                                         : {1'b0, cap_ff};
   assign full    = {1'b0, size_ff} >= eff_cap;
   assign seen    = mask_ff[req_node];
   assign size_m1 = size_ff - CNT_W'(1);

   // A push lands at the current size; a pop reads the tail, one below it.
   // The only write happens on an accepted push; the memory is read every cycle at the
   // tail, and a pop uses that registered read data in the following cycle while busy.
   assign wr_addr  = size_ff[AW-1:0];
   assign rd_addr  = size_m1[AW-1:0];
   assign dist_eff = (size_ff == '0) ? '0 : req_edge_distance;
   assign wr_data  = '{node: req_node, distance: dist_eff};

   always_comb begin
      size_in     = size_ff;
      len_in      = len_ff;
      mask_in     = mask_ff;
      pop_pend_in = 1'b0;
      strobe_in   = 1'b0;
      stat_in     = ST_DONE;
      wr_en       = 1'b0;
      if (pop_pend_ff) begin
         // Pending pop: the tail entry is now available.
         strobe_in = 1'b1;
         if (size_ff != '0) begin
            size_in = size_m1;
            mask_in = mask_ff & ~(MASK_W'(1) << rd_data_ff.node);
         end
         if (size_ff > CNT_W'(1)) begin
            len_in = len_ff - LEN_W'(rd_data_ff.distance);
         end else begin
            len_in = '0;
         end
      end else if (accept) begin
         unique case (op)
            OP_PUSH, OP_PUSH_CHECKED: begin
               strobe_in = 1'b1;
               if (op == OP_PUSH_CHECKED && seen) begin
                  stat_in = ST_REFUSED;
               end else if (full) begin
                  stat_in = ST_OVERFLOW;
               end else begin
                  wr_en   = 1'b1;
                  size_in = size_ff + CNT_W'(1);
                  len_in  = len_ff + LEN_W'(dist_eff);
                  mask_in = mask_ff | (MASK_W'(1) << req_node);
               end
            end
            OP_POP: begin
               pop_pend_in = 1'b1;
            end
            OP_CLEAR: begin
               strobe_in = 1'b1;
               size_in   = '0;
               len_in    = '0;
               mask_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= '0;
         len_ff      <= '0;
         mask_ff     <= '0;
         cap_ff      <= CNT_W'(32);
         pop_pend_ff <= 1'b0;
         strobe_ff   <= 1'b0;
         stat_ff     <= ST_DONE;
      end else begin
         size_ff     <= size_in;
         len_ff      <= len_in;
         mask_ff     <= mask_in;
         pop_pend_ff <= pop_pend_in;
         strobe_ff   <= strobe_in;
         stat_ff     <= stat_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Results always show the state after the command.
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = stat_ff;
   assign rsp_node_count  = size_ff;
   assign rsp_tour_length = len_ff;
   assign rsp_visited_set = mask_ff;

   a_cmd_result: assert property (@(posedge clock) disable iff (reset)
      accept && op != OP_POP |=> rsp_strobe)
      else $error("push or clear gave no result in the next cycle");

   a_pop_two_cycles: assert property (@(posedge clock) disable iff (reset)
      accept && op == OP_POP |=> busy && !rsp_strobe ##1 rsp_strobe && !busy)
      else $error("pop did not finish in two cycles");

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, size_ff} <= CAP_W'(MAX_NODES))
      else $error("node count beyond memory depth");

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      size_ff == '0 |-> mask_ff == '0 && len_ff == '0)
      else $error("empty path with nonzero bitmap or length");

   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && stat_ff != ST_DONE |-> $stable(size_ff) && $stable(mask_ff))
      else $error("refused push changed the path");

endmodule
`default_nettype wire
